[sv/event_gap_segmenter_top_defines.svh]
// Assertion macros for the event gap segmenter checker.
// A body holds one concurrent assertion; ante and cons are boolean expressions.
`ifndef EVENT_GAP_SEGMENTER_TOP_DEFINES_SVH
`define EVENT_GAP_SEGMENTER_TOP_DEFINES_SVH

// cons must hold in the same cycle as ante
`define EGS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define EGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/egs_pkg.sv]
`timescale 1ns / 1ps

package egs_pkg;

   localparam int CFG_W = 32;

   localparam logic [CFG_W-1:0] MIN_SIZE_RST     = 32'd100;
   localparam logic [CFG_W-1:0] MAX_SIZE_RST     = 32'd1000;
   localparam logic [CFG_W-1:0] GUARD_LEN_RST    = 32'd0;
   localparam logic [CFG_W-1:0] TOTAL_LENGTH_RST = 32'd1048576;

   // register indexes on the csr port
   localparam logic [1:0] CSR_MIN_SIZE     = 2'd0;
   localparam logic [1:0] CSR_MAX_SIZE     = 2'd1;
   localparam logic [1:0] CSR_GUARD_LEN    = 2'd2;
   localparam logic [1:0] CSR_TOTAL_LENGTH = 2'd3;

   // settings as seen by the datapath; stride and close_time are already sanitised
   typedef struct packed {
      logic [CFG_W-1:0] min_size;
      logic [CFG_W-1:0] stride;
      logic [CFG_W-1:0] guard_len;
      logic [CFG_W-1:0] close_time;
   } cfg_type;

endpackage

[sv/egs_channels.sv]
`timescale 1ns / 1ps

interface egs_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] event_time;
   logic        end_of_list;

   modport source (output valid, event_time, end_of_list, input ready);
   modport sink   (input valid, event_time, end_of_list, output ready);
endinterface

interface egs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] seg_start;
   logic [31:0] seg_end;
   logic        last_of_run;
   logic        truncated;

   modport source  (output valid, seg_start, seg_end, last_of_run, truncated, input ready);
   modport sink    (input valid, seg_start, seg_end, last_of_run, truncated, output ready);
   modport monitor (input valid, ready, seg_start, seg_end, last_of_run, truncated);
endinterface

[sv/event_gap_segmenter_top.sv]
`timescale 1ns / 1ps
// An accepted req word passes the front states DIFF, SPAN and PUSH, then the job queue and the segment emitter.
// The front takes no new event until the current one has left PUSH, which waits while the queue is full; the
// back emits one segment per cycle while rsp_ch does not stall, and pops the next job once a run has ended.
// A two-entry job queue lets the front run ahead of the segment emitter.
// Reset (synchronous): settings to defaults, previous event time to 0, queue and output empty.
module event_gap_segmenter_top #(
   parameter int TIME_BITS        = 32,
   parameter int MAX_SEGS_PER_GAP = 64
) (
   input  logic        clock,
   input  logic        reset,
   egs_req_if.sink     req_ch,
   egs_rsp_if.source   rsp_ch,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import egs_pkg::*;

   localparam int QW = 2 * TIME_BITS + 1;

   logic [CFG_W-1:0] min_ff, max_ff, guard_ff, total_ff;
   cfg_type          cfg;

   logic                 job_full, job_push, job_trunc, job_pop, job_empty;
   logic [TIME_BITS-1:0] job_start, job_span;
   logic [QW-1:0]        q_in, q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= MIN_SIZE_RST;
         max_ff   <= MAX_SIZE_RST;
         guard_ff <= GUARD_LEN_RST;
         total_ff <= TOTAL_LENGTH_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_SIZE:     min_ff   <= csr_wdata;
            CSR_MAX_SIZE:     max_ff   <= csr_wdata;
            CSR_GUARD_LEN:    guard_ff <= csr_wdata;
            CSR_TOTAL_LENGTH: total_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.min_size   = min_ff;
      cfg.stride     = (max_ff == '0) ? CFG_W'(1) : max_ff;
      cfg.guard_len  = guard_ff;
      cfg.close_time = (total_ff == '0) ? '0 : total_ff - CFG_W'(1);
   end

   egs_front #(
      .TIME_BITS        (TIME_BITS),
      .MAX_SEGS_PER_GAP (MAX_SEGS_PER_GAP)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_ch    (req_ch),
      .job_full  (job_full),
      .job_push  (job_push),
      .job_start (job_start),
      .job_span  (job_span),
      .job_trunc (job_trunc)
   );

   assign q_in = {job_trunc, job_start, job_span};

   egs_queue #(
      .W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (q_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (q_out),
      .empty     (job_empty)
   );

   egs_back #(
      .TIME_BITS        (TIME_BITS),
      .MAX_SEGS_PER_GAP (MAX_SEGS_PER_GAP)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_valid (!job_empty),
      .job_pop   (job_pop),
      .job_start (q_out[QW-2:TIME_BITS]),
      .job_span  (q_out[TIME_BITS-1:0]),
      .job_trunc (q_out[QW-1]),
      .rsp_ch    (rsp_ch)
   );

endmodule

[sv/egs_front.sv]
`timescale 1ns / 1ps

module egs_front #(
   parameter int TIME_BITS        = 32,
   parameter int MAX_SEGS_PER_GAP = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  egs_pkg::cfg_type     cfg,
   egs_req_if.sink              req_ch,
   input  logic                 job_full,
   output logic                 job_push,
   output logic [TIME_BITS-1:0] job_start,
   output logic [TIME_BITS-1:0] job_span,
   output logic                 job_trunc
);
   localparam int TB = TIME_BITS;
   localparam int WB = (TB > 32) ? TB : 32;
   localparam int CW = WB + 8;
   localparam logic [CW-1:0] SEG_MUL = CW'(MAX_SEGS_PER_GAP);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIFF = 2'd1;
   localparam logic [1:0] ST_SPAN = 2'd2;
   localparam logic [1:0] ST_PUSH = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [TB-1:0] prev_ff, target_in, target_ff, base_ff;
   logic [CW-1:0] gap_ff, thr_ff, mst_ff, span_ff, mm_ff, start_ff;
   logic          pos_ff, okstr_ff, hit_ff;
   logic          accept;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign target_in    = req_ch.end_of_list ? TB'(cfg.close_time) : TB'(req_ch.event_time);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DIFF;
         end
         ST_DIFF: state_in = ST_SPAN;
         ST_SPAN: state_in = ST_PUSH;
         ST_PUSH: begin
            if (!hit_ff || !job_full) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) prev_ff <= req_ch.end_of_list ? '0 : target_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         target_ff <= target_in;
         base_ff   <= prev_ff;
      end
      if (state_ff == ST_DIFF) begin
         gap_ff   <= CW'(target_ff) - CW'(base_ff);
         pos_ff   <= target_ff > base_ff;
         thr_ff   <= CW'(cfg.min_size) + (CW'(cfg.guard_len) << 1);
         mst_ff   <= CW'(cfg.stride) * SEG_MUL;
         okstr_ff <= cfg.stride >= cfg.min_size;
      end
      if (state_ff == ST_SPAN) begin
         hit_ff   <= pos_ff && okstr_ff && (gap_ff > thr_ff);
         span_ff  <= gap_ff - (CW'(cfg.guard_len) << 1);
         mm_ff    <= mst_ff + CW'(cfg.min_size);
         start_ff <= CW'(base_ff) + CW'(cfg.guard_len);
      end
   end

   // more qualifying pieces than the run may carry
   assign job_trunc = (span_ff > mst_ff) && (span_ff >= mm_ff);
   assign job_push  = (state_ff == ST_PUSH) && hit_ff && !job_full;
   assign job_start = TB'(start_ff);
   assign job_span  = TB'(span_ff);

endmodule

[sv/egs_queue.sv]
`timescale 1ns / 1ps

module egs_queue #(
   parameter int W = 65
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty
);
   localparam int DEPTH = 2;
   localparam int AW    = $clog2(DEPTH);

   logic [W-1:0]  slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + AW'(1);
         if (pop)  rd_ff <= rd_ff + AW'(1);
         if (push && !pop)      cnt_ff <= cnt_ff + (AW+1)'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

endmodule

[sv/egs_back.sv]
`timescale 1ns / 1ps

module egs_back #(
   parameter int TIME_BITS        = 32,
   parameter int MAX_SEGS_PER_GAP = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  egs_pkg::cfg_type     cfg,
   input  logic                 job_valid,
   output logic                 job_pop,
   input  logic [TIME_BITS-1:0] job_start,
   input  logic [TIME_BITS-1:0] job_span,
   input  logic                 job_trunc,
   egs_rsp_if.source            rsp_ch
);
   localparam int TB   = TIME_BITS;
   localparam int SW   = ((TB > 32) ? TB : 32) + 1;
   localparam int CNTW = (MAX_SEGS_PER_GAP > 1) ? $clog2(MAX_SEGS_PER_GAP) : 1;
   localparam logic [CNTW-1:0] CNT_LAST = CNTW'(MAX_SEGS_PER_GAP - 1);

   logic                 act_ff;
   logic [TB-1:0]        start_ff, span_ff;
   logic signed [SW-1:0] nspan_ff;
   logic [CNTW-1:0]      cnt_ff;
   logic                 trunc_ff;

   logic                 ov_ff;
   logic [TB-1:0]        ostart_ff, oend_ff;
   logic                 olast_ff, otrunc_ff;

   logic                 fire, full_piece, last;
   logic [TB-1:0]        stride_tb, end_in;
   logic signed [SW-1:0] min_s, stride_s;

   assign stride_tb  = TB'(cfg.stride);
   assign stride_s   = $signed(SW'(cfg.stride));
   assign min_s      = $signed(SW'(cfg.min_size));

   assign job_pop    = !act_ff && job_valid;
   assign fire       = act_ff && (!ov_ff || rsp_ch.ready);
   // nspan is what is left after a full stride; positive means this piece is full
   assign full_piece = !nspan_ff[SW-1] && (nspan_ff != '0);
   assign last       = !full_piece || (nspan_ff < min_s) || (cnt_ff == CNT_LAST);
   assign end_in     = start_ff + (full_piece ? stride_tb : span_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         ov_ff  <= 1'b0;
      end else begin
         if (job_pop)           act_ff <= 1'b1;
         else if (fire && last) act_ff <= 1'b0;
         if (fire)              ov_ff  <= 1'b1;
         else if (rsp_ch.ready) ov_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         start_ff <= job_start;
         span_ff  <= job_span;
         nspan_ff <= $signed(SW'(job_span)) - stride_s;
         cnt_ff   <= '0;
         trunc_ff <= job_trunc;
      end else if (fire && !last) begin
         start_ff <= start_ff + stride_tb;
         span_ff  <= TB'(nspan_ff);
         nspan_ff <= nspan_ff - stride_s;
         cnt_ff   <= cnt_ff + CNTW'(1);
      end
      if (fire) begin
         ostart_ff <= start_ff;
         oend_ff   <= end_in;
         olast_ff  <= last;
         otrunc_ff <= trunc_ff;
      end
   end

   assign rsp_ch.valid       = ov_ff;
   assign rsp_ch.seg_start   = 32'(ostart_ff);
   assign rsp_ch.seg_end     = 32'(oend_ff);
   assign rsp_ch.last_of_run = olast_ff;
   assign rsp_ch.truncated   = otrunc_ff;

endmodule

[sv/egs_checker.sv]
`timescale 1ns / 1ps
`include "event_gap_segmenter_top_defines.svh"

module egs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_seg_start,
   input logic [31:0] rsp_seg_end,
   input logic        rsp_last_of_run,
   input logic        rsp_truncated
);
   logic        mid_ff;
   logic        ptrunc_ff;
   logic [31:0] pend_ff;

   // remembers the previous word of a run still in progress
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         mid_ff <= !rsp_last_of_run;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         ptrunc_ff <= rsp_truncated;
         pend_ff   <= rsp_seg_end;
      end
   end

   `EGS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_seg_start) && $stable(rsp_seg_end), "rsp word changed while stalled")
   `EGS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "rsp valid right after reset")
   `EGS_ASSERT_SAME(a_seg_order, clock, reset, rsp_valid, rsp_seg_end > rsp_seg_start, "segment end not above start")
   `EGS_ASSERT_SAME(a_run_contig, clock, reset, rsp_valid && mid_ff, rsp_seg_start == pend_ff && rsp_truncated == ptrunc_ff, "segment run not contiguous")

endmodule

bind event_gap_segmenter_top egs_checker u_egs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_seg_start   (rsp_ch.seg_start),
   .rsp_seg_end     (rsp_ch.seg_end),
   .rsp_last_of_run (rsp_ch.last_of_run),
   .rsp_truncated   (rsp_ch.truncated)
);

[bench/event_gap_segmenter_top_test.sv]
`timescale 1ns / 1ps

module event_gap_segmenter_top_test;

   import egs_pkg::*;

   localparam int MAX_SEGS_PER_GAP = 64;
   localparam int SETTLE_CYCLES    = 40;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT      = 2_000_000;
   localparam int PHASE_EVENTS     = 35;

   typedef struct packed {
      logic [31:0] event_time;
      logic        end_of_list;
   } event_word_type;

   typedef struct packed {
      logic [31:0] seg_start;
      logic [31:0] seg_end;
      logic        last_of_run;
      logic        truncated;
   } segment_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [31:0] csr_wdata = 32'd0;
   logic        rsp_hold = 1'b0;

   egs_req_if req_ch ();
   egs_rsp_if rsp_ch ();

   event_gap_segmenter_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // shadow of the settings and of the previous event time
   logic [CFG_W-1:0] cfg_min_size     = MIN_SIZE_RST;
   logic [CFG_W-1:0] cfg_max_size     = MAX_SIZE_RST;
   logic [CFG_W-1:0] cfg_guard_len    = GUARD_LEN_RST;
   logic [CFG_W-1:0] cfg_total_length = TOTAL_LENGTH_RST;
   logic [31:0]      prev_event       = 32'd0;

   event_word_type pending_events[$];
   segment_type    expected_segments[$];
   event_word_type offered_event;
   logic [31:0]    gen_time = 32'd0;

   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int unsigned events_queued   = 0;
   int unsigned events_accepted = 0;
   int unsigned segments_seen   = 0;
   int unsigned cut_runs_seen   = 0;
   int unsigned settings_used   = 0;
   int unsigned mismatch_count  = 0;
   int unsigned cycle_count     = 0;

   always #5 clock = ~clock;

   // Walks the gap from the previous event to the new target and queues the segments it yields.
   function automatic void predict_segments(event_word_type w);
      logic [63:0] target;
      logic [63:0] base;
      logic [63:0] stride;
      logic [63:0] min_len;
      logic [63:0] guard;
      logic [63:0] gap;
      logic [63:0] limit;
      logic [63:0] pos;
      logic [63:0] span;
      logic [63:0] piece;
      logic [63:0] sum;
      segment_type run[$];
      segment_type s;
      bit          dropped;
      dropped = 1'b0;
      base    = {32'd0, prev_event};
      stride  = (cfg_max_size == '0) ? 64'd1 : {32'd0, cfg_max_size};
      min_len = {32'd0, cfg_min_size};
      guard   = {32'd0, cfg_guard_len};
      if (w.end_of_list)
         target = (cfg_total_length == '0) ? 64'd0 : {32'd0, cfg_total_length - 32'd1};
      else
         target = {32'd0, w.event_time};
      if (target > base && stride >= min_len) begin
         gap = target - base;
         if (gap > min_len + (guard << 1)) begin
            limit = gap - guard;
            pos   = guard;
            while (pos < limit) begin
               span  = limit - pos;
               piece = (span > stride) ? stride : span;
               if (piece >= min_len) begin
                  if (run.size() >= MAX_SEGS_PER_GAP) begin
                     dropped = 1'b1;
                     break;
                  end
                  sum         = base + pos;
                  s.seg_start = sum[31:0];
                  sum         = base + pos + piece;
                  s.seg_end   = sum[31:0];
                  s.last_of_run = 1'b0;
                  s.truncated   = 1'b0;
                  run.push_back(s);
               end
               if (span <= stride)
                  break;
               pos = pos + stride;
            end
         end
      end
      foreach (run[k]) begin
         s             = run[k];
         s.last_of_run = (k == run.size() - 1);
         s.truncated   = dropped;
         expected_segments.push_back(s);
      end
      prev_event = w.end_of_list ? 32'd0 : target[31:0];
   endfunction

   function automatic void note_mismatch(string what, segment_type want, segment_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"[%0t] %s: expected start=%0d end=%0d last=%0b trunc=%0b,",
                   " got start=%0d end=%0d last=%0b trunc=%0b"},
                  $time, what, want.seg_start, want.seg_end, want.last_of_run, want.truncated,
                  got.seg_start, got.seg_end, got.last_of_run, got.truncated);
   endfunction

   function automatic void check_segment(segment_type got);
      segment_type want;
      string       fields;
      segments_seen++;
      if (got.last_of_run && got.truncated)
         cut_runs_seen++;
      if (expected_segments.size() == 0) begin
         note_mismatch("segment with none pending", '0, got);
      end else begin
         want   = expected_segments.pop_front();
         fields = "";
         if (got.seg_start !== want.seg_start)     fields = {fields, " seg_start"};
         if (got.seg_end !== want.seg_end)         fields = {fields, " seg_end"};
         if (got.last_of_run !== want.last_of_run) fields = {fields, " last_of_run"};
         if (got.truncated !== want.truncated)     fields = {fields, " truncated"};
         if (fields != "")
            note_mismatch({"wrong", fields}, want, got);
      end
   endfunction

   // driver: holds a word until taken, otherwise may idle
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!(req_ch.valid && !req_ch.ready)) begin
         if (req_ch.valid && req_ch.ready) begin
            predict_segments(offered_event);
            events_accepted++;
         end
         if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offered_event      = pending_events.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.event_time  <= offered_event.event_time;
            req_ch.end_of_list <= offered_event.end_of_list;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_segment('{rsp_ch.seg_start, rsp_ch.seg_end, rsp_ch.last_of_run,
                            rsp_ch.truncated});
         rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[%0t] run did not finish in time", $time);
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic queue_event(logic [31:0] t, logic eol);
      @(negedge clock);
      pending_events.push_back('{t, eol});
      events_queued++;
   endtask

   function automatic event_word_type random_event();
      event_word_type w;
      int             r;
      logic [32:0]    sum;
      r = $urandom_range(99);
      w.end_of_list = 1'b0;
      if (r < 8) begin
         w.end_of_list = 1'b1;
         w.event_time  = $urandom;
         gen_time      = 32'd0;
      end else if (r < 13) begin
         // out-of-sequence word, mostly far above or below the running time
         w.event_time = $urandom;
      end else begin
         sum          = {1'b0, gen_time} + ((r < 17) ? $urandom_range(120000, 30000)
                                                     : $urandom_range(6000, 0));
         gen_time     = sum[31:0];
         w.event_time = gen_time;
      end
      return w;
   endfunction

   task automatic queue_random_events(int count);
      @(negedge clock);
      repeat (count) begin
         pending_events.push_back(random_event());
         events_queued++;
      end
   endtask

   task automatic wait_drained();
      while (events_accepted != events_queued || expected_segments.size() != 0)
         @(posedge clock);
      // words that yield no segment may still be in the pipe
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
   endtask

   task automatic apply_settings(logic [31:0] min_v, logic [31:0] max_v,
                                 logic [31:0] guard_v, logic [31:0] total_v);
      wait_drained();
      write_reg(CSR_MIN_SIZE, min_v);
      write_reg(CSR_MAX_SIZE, max_v);
      write_reg(CSR_GUARD_LEN, guard_v);
      write_reg(CSR_TOTAL_LENGTH, total_v);
      @(posedge clock);
      csr_write_en     <= 1'b0;
      cfg_min_size     = min_v;
      cfg_max_size     = max_v;
      cfg_guard_len    = guard_v;
      cfg_total_length = total_v;
      settings_used++;
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      int modes[4][2];
      modes = '{'{0, 0}, '{82, 0}, '{0, 82}, '{26, 26}};
      req_ch.valid       = 1'b0;
      req_ch.event_time  = 32'd0;
      req_ch.end_of_list = 1'b0;
      rsp_ch.ready       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      settings_used = 1;

      // settings straight after reset
      queue_event(32'd0, 1'b0);          // equal to the previous time
      queue_event(32'd50, 1'b0);         // gap too short
      queue_event(32'd2550, 1'b0);       // two full strides and a short tail
      queue_event(32'd2600, 1'b0);
      queue_event(32'd1000, 1'b0);       // descending
      queue_event(32'd72000, 1'b0);      // more pieces than allowed per gap
      queue_event(32'd2000, 1'b1);       // close the list
      queue_event(32'hFFFF_FFFF, 1'b0);
      queue_event(32'hFFFF_FFFF, 1'b1);  // closing time below the previous event

      // zero stride and zero length
      apply_settings(32'd0, 32'd0, 32'd0, 32'd0);
      queue_event(32'd0, 1'b1);
      queue_event(32'd5, 1'b0);
      queue_event(32'd300, 1'b0);
      queue_event(32'hA5A5_A5A5, 1'b1);

      apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_event(32'hFFFF_FFFF, 1'b0);
      queue_event(32'd0, 1'b1);

      // one segment spanning the whole time range
      apply_settings(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      queue_event(32'hFFFF_FFFF, 1'b0);
      queue_event(32'd0, 1'b1);
      queue_event(32'd0, 1'b1);

      // stride below the minimum length
      apply_settings(32'd500, 32'd400, 32'd10, 32'd100000);
      queue_event(32'd50000, 1'b0);
      queue_event(32'd0, 1'b1);

      // wide guard
      apply_settings(32'd10, 32'd100, 32'd1000, 32'd5000);
      queue_event(32'd2000, 1'b0);
      queue_event(32'd5000, 1'b0);
      queue_event(32'd0, 1'b1);

      foreach (modes[m]) begin
         repeat (2) begin
            apply_settings($urandom_range(400, 0), $urandom_range(3000, 0),
                           $urandom_range(200, 0), $urandom_range(50000, 1));
            set_idling(modes[m][0], modes[m][1]);
            queue_random_events(PHASE_EVENTS);
         end
      end

      // receiver holds off while the sender keeps offering, so the input backs up
      apply_settings(32'd10, 32'd200, 32'd5, 32'd20000);
      set_idling(0, 0);
      @(posedge clock);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      queue_random_events(30);

      wait_drained();
      $display("%0d event words over %0d register settings, %0d segments checked",
               events_accepted, settings_used, segments_seen);
      $display("%0d runs cut at the per-gap segment limit", cut_runs_seen);
      if (mismatch_count == 0 && expected_segments.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/egs_pkg.sv
sv/egs_channels.sv
sv/egs_front.sv
sv/egs_queue.sv
sv/egs_back.sv
sv/event_gap_segmenter_top.sv
sv/egs_checker.sv
bench/event_gap_segmenter_top_test.sv
